### rtl/slb_pkg.sv
// Shared types, constants and state codes for the Sauvola local binarizer.
// No dependencies; the unit and the pixel store refer to it by scoped names.
package slb_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_WINDOW = 31;
    localparam int MAX_HEIGHT     = 4096;

    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int ROW_W   = 13;
    localparam int FRAC_W  = 16;
    localparam int MEAN_W  = 24;
    localparam int VAR_W   = 32;
    localparam int SD_W    = 24;
    localparam int SQ_IN_W = 2 * SD_W;
    localparam int RAT_W   = 24;
    localparam int TERM_W  = 26;
    localparam int K_W     = 16;
    localparam int PROD_W  = TERM_W + K_W + 1;
    localparam int F_W     = 25;
    localparam int GRAY_W  = 8;
    localparam int MF_W    = MEAN_W + F_W;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int WIDTH_CFG_W = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int WSIZE_CFG_W = 5;
    localparam int RDIV_CFG_W  = 8;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [WSIZE_CFG_W-1:0]  WSIZE_RST  = 5'd15;
    localparam logic [K_W-1:0]          K_RST      = 16'd13107;
    localparam logic [RDIV_CFG_W-1:0]   RDIV_RST   = 8'd127;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_K_FACTOR      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_DIVISOR = 3'd4;

    localparam logic [15:0] GRAY_R = 16'd19588;
    localparam logic [15:0] GRAY_G = 16'd38470;
    localparam logic [15:0] GRAY_B = 16'd7471;
    localparam int          ONE_Q16 = 65536;

    typedef struct packed {
        logic            mode;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } in_item_t;

    typedef struct packed {
        logic foreground;
        logic frame_end;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ADDR,
        ST_READ,
        ST_READ_END,
        ST_MUL,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_RAT_GO,
        ST_RAT_WAIT,
        ST_PROD,
        ST_FACT,
        ST_SCALE,
        ST_DONE
    } state_t;

endpackage

### rtl/sauvola_local_binarizer_unit.sv
// Sauvola local binarizer: pixel store, window sequencer and threshold arithmetic.
// Depends on slb_pkg, slb_pixel_store, slb_div and slb_sqrt.
//
// Usage:
// s_valid/s_ready/s_data take one beat per pixel (mode 0) in raster order,
// or a drain beat (mode 1) once the whole frame is in. m_valid/m_ready/m_data
// return one binarized pixel per result, frame_end marking the last one.
// Results lag the input by half*width+half pixels; drain beats flush the rest.
// A beat is taken only while the sequencer is idle. For a beat with a result,
// the window walk reads the pixel store once per window pixel, then the shared
// bit-serial divider runs three times (mean, variance, scaling by R) around the
// bit-serial root.
// The result register holds a finished beat while m_ready is low; the next
// input beat is still taken, and a new result waits until that register frees.
// Reset restores the register defaults and starts a new frame; the pixel
// store needs no clearing. A register write also starts a new frame.
module sauvola_local_binarizer_unit #(
    parameter int MAX_WIDTH  = slb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = slb_pkg::DEF_MAX_WINDOW
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  slb_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output slb_pkg::out_item_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [slb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [slb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH    = MAX_WINDOW * MAX_WIDTH;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WID_W    = $clog2(MAX_WIDTH + 1);
    localparam int HALF_A   = (MAX_WINDOW - 1) / 2;
    localparam int HALF_B   = (MAX_WIDTH - 1) / 2;
    localparam int HALF_MAX = (HALF_A < HALF_B) ? HALF_A : HALF_B;
    localparam int HALF_W   = $clog2(HALF_MAX + 1);
    localparam int SPAN     = 2 * HALF_MAX + 1;
    localparam int SPAN_W   = $clog2(SPAN + 1);
    localparam int CNT_MAX  = 3 * SPAN * SPAN;
    localparam int C_W      = $clog2(CNT_MAX + 1);
    localparam int S_W      = $clog2(CNT_MAX * 255 + 1);
    localparam int Q_W      = $clog2(CNT_MAX * 65025 + 1);
    localparam int CQ_W     = C_W + Q_W;
    localparam int NUM_W    = CQ_W + slb_pkg::FRAC_W;
    localparam int DEN_W    = 2 * C_W;
    localparam int IDX_W    = $clog2(MAX_WIDTH * slb_pkg::MAX_HEIGHT + 1);
    localparam int ROW_W    = slb_pkg::ROW_W;
    localparam logic [ADDR_W:0] DEPTH_A = (ADDR_W + 1)'(DEPTH);

    // configuration
    logic [slb_pkg::WIDTH_CFG_W-1:0]  width_reg;
    logic [slb_pkg::HEIGHT_CFG_W-1:0] height_reg;
    logic [slb_pkg::WSIZE_CFG_W-1:0]  wsize_reg;
    logic [slb_pkg::K_W-1:0]          k_reg;
    logic [slb_pkg::RDIV_CFG_W-1:0]   rdiv_reg;
    logic                             cfg_hit;

    // frame positions
    logic [COL_W-1:0]  in_col_reg, out_col_reg;
    logic [ROW_W-1:0]  in_row_reg, out_row_reg;
    logic [IDX_W-1:0]  in_idx_reg, out_idx_reg;
    logic [ADDR_W-1:0] in_addr_reg, out_addr_reg;

    // window walk
    logic [COL_W-1:0]  x0_reg, x1_reg, xi_reg;
    logic [ROW_W-1:0]  y0_reg, y1_reg, yi_reg;
    logic [HALF_W-1:0] dx_reg, dy_reg;
    logic [ADDR_W-1:0] back_reg, cur_reg, row_reg;
    logic [C_W-1:0]    c_reg;
    logic [S_W-1:0]    s_reg;
    logic [Q_W-1:0]    q_reg;
    logic              acc_en_reg;

    // arithmetic
    logic [slb_pkg::GRAY_W-1:0]        gray_reg;
    logic [CQ_W-1:0]                   cq_reg, ss_reg;
    logic [DEN_W-1:0]                  den_reg;
    logic [slb_pkg::MEAN_W-1:0]        mean_reg;
    logic [slb_pkg::VAR_W-1:0]         var_reg;
    logic [slb_pkg::SD_W-1:0]          sd_reg;
    logic [slb_pkg::RAT_W-1:0]         rat_reg;
    logic signed [slb_pkg::PROD_W-1:0] prod_reg;
    logic [slb_pkg::F_W-1:0]           f_reg;
    logic [slb_pkg::MF_W-1:0]          mf_reg;

    slb_pkg::out_item_t out_reg;
    logic               out_full_reg;
    slb_pkg::state_t    state_reg, state_next;

    // combinational
    logic [31:0]       w_tmp, h_tmp, half_tmp;
    logic [WID_W-1:0]  w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [HALF_W-1:0] half;
    logic [IDX_W-1:0]  n_frame, lag, fill;
    logic [slb_pkg::RDIV_CFG_W-1:0] rdiv_eff;
    logic              accept, px_ok, drain_ok, emit, frame_end, load_out;
    logic [COL_W-1:0]  wm1, x0_c, x1_c;
    logic [COL_W:0]    xe;
    logic [ROW_W-1:0]  hm1, y0_c, y1_c;
    logic [ROW_W:0]    ye;
    logic [ADDR_W:0]   addr_inc, cur_inc, row_add, back_sub;
    logic [ADDR_W-1:0] rd_addr;
    logic [slb_pkg::PIX_W-1:0] rd_data;
    logic [slb_pkg::CH_W-1:0]  pr, pg, pb;
    logic [15:0]       rr, gg, bb;
    logic [23:0]       gray_sum;
    logic [SPAN_W-1:0] xn, yn;
    logic [CQ_W-1:0]   var_diff;
    logic              div_start, div_done, sq_start, sq_done;
    logic [NUM_W-1:0]  div_dividend, div_quo;
    logic [DEN_W-1:0]  div_divisor;
    logic [slb_pkg::SD_W-1:0]          sq_root;
    logic signed [slb_pkg::TERM_W-1:0] term;
    logic signed [slb_pkg::K_W:0]      k_s;
    logic signed [slb_pkg::PROD_W-1:0] fsum;
    logic [slb_pkg::MF_W-1:0]          gray_sh;

    // effective configuration
    always_comb begin
        w_tmp = 32'(width_reg);
        if (w_tmp == 32'd0) begin
            w_tmp = 32'd1;
        end else if (w_tmp > 32'(MAX_WIDTH)) begin
            w_tmp = 32'(MAX_WIDTH);
        end
        h_tmp = 32'(height_reg);
        if (h_tmp == 32'd0) begin
            h_tmp = 32'd1;
        end else if (h_tmp > 32'(slb_pkg::MAX_HEIGHT)) begin
            h_tmp = 32'(slb_pkg::MAX_HEIGHT);
        end
        half_tmp = 32'(wsize_reg[slb_pkg::WSIZE_CFG_W-1:1]);
        if (half_tmp > 32'(HALF_MAX)) begin
            half_tmp = 32'(HALF_MAX);
        end
        w_eff    = WID_W'(w_tmp);
        h_eff    = ROW_W'(h_tmp);
        half     = HALF_W'(half_tmp);
        rdiv_eff = (rdiv_reg == '0) ? slb_pkg::RDIV_CFG_W'(1) : rdiv_reg;
        n_frame  = IDX_W'(w_eff) * IDX_W'(h_eff);
        lag      = IDX_W'(half) * IDX_W'(w_eff) + IDX_W'(half);
    end

    // item decision
    always_comb begin
        accept    = s_valid && s_ready;
        px_ok     = !s_data.mode && (in_idx_reg < n_frame);
        drain_ok  = (in_idx_reg >= n_frame) && (out_idx_reg < n_frame);
        fill      = in_idx_reg + IDX_W'(1) - out_idx_reg;
        emit      = px_ok ? (fill > lag) : drain_ok;
        frame_end = (out_idx_reg + IDX_W'(1)) == n_frame;
        load_out  = (state_reg == slb_pkg::ST_DONE) && (!out_full_reg || m_ready);
    end

    // window bounds around the output position
    always_comb begin
        wm1  = COL_W'(w_eff - WID_W'(1));
        hm1  = h_eff - ROW_W'(1);
        x0_c = (out_col_reg > COL_W'(half)) ? out_col_reg - COL_W'(half) : '0;
        xe   = (COL_W + 1)'(out_col_reg) + (COL_W + 1)'(half);
        x1_c = (xe > (COL_W + 1)'(wm1)) ? wm1 : COL_W'(xe);
        y0_c = (out_row_reg > ROW_W'(half)) ? out_row_reg - ROW_W'(half) : '0;
        ye   = (ROW_W + 1)'(out_row_reg) + (ROW_W + 1)'(half);
        y1_c = (ye > (ROW_W + 1)'(hm1)) ? hm1 : ROW_W'(ye);
    end

    // circular address arithmetic
    always_comb begin
        addr_inc = (ADDR_W + 1)'(in_addr_reg) + (ADDR_W + 1)'(1);
        if (addr_inc >= DEPTH_A) begin
            addr_inc = '0;
        end
        cur_inc = (ADDR_W + 1)'(cur_reg) + (ADDR_W + 1)'(1);
        if (cur_inc >= DEPTH_A) begin
            cur_inc = '0;
        end
        row_add = (ADDR_W + 1)'(row_reg) + (ADDR_W + 1)'(w_eff);
        if (row_add >= DEPTH_A) begin
            row_add = row_add - DEPTH_A;
        end
        if (back_reg > out_addr_reg) begin
            back_sub = (ADDR_W + 1)'(out_addr_reg) + DEPTH_A - (ADDR_W + 1)'(back_reg);
        end else begin
            back_sub = (ADDR_W + 1)'(out_addr_reg) - (ADDR_W + 1)'(back_reg);
        end
    end

    // pixel decode
    always_comb begin
        pr       = rd_data[3*slb_pkg::CH_W-1:2*slb_pkg::CH_W];
        pg       = rd_data[2*slb_pkg::CH_W-1:slb_pkg::CH_W];
        pb       = rd_data[slb_pkg::CH_W-1:0];
        rr       = 16'(pr) * 16'(pr);
        gg       = 16'(pg) * 16'(pg);
        bb       = 16'(pb) * 16'(pb);
        gray_sum = 24'(slb_pkg::GRAY_R) * 24'(pr) + 24'(slb_pkg::GRAY_G) * 24'(pg)
                 + 24'(slb_pkg::GRAY_B) * 24'(pb);
        xn       = SPAN_W'(x1_reg - x0_reg) + SPAN_W'(1);
        yn       = SPAN_W'(y1_reg - y0_reg) + SPAN_W'(1);
        var_diff = cq_reg - ss_reg;
        k_s      = $signed({1'b0, k_reg});
        term     = $signed({2'b00, rat_reg}) - $signed(slb_pkg::TERM_W'(slb_pkg::ONE_Q16));
        fsum     = (prod_reg >>> slb_pkg::FRAC_W)
                 + $signed(slb_pkg::PROD_W'(slb_pkg::ONE_Q16));
        gray_sh  = slb_pkg::MF_W'({gray_reg, 32'd0});
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        div_start    = 1'b0;
        sq_start     = 1'b0;
        div_dividend = NUM_W'({s_reg, 16'd0});
        div_divisor  = DEN_W'(c_reg);
        rd_addr      = cur_reg;
        case (state_reg)
            slb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && emit) begin
                    state_next = slb_pkg::ST_SETUP;
                end
            end
            slb_pkg::ST_SETUP: begin
                rd_addr    = out_addr_reg;
                state_next = slb_pkg::ST_ADDR;
            end
            slb_pkg::ST_ADDR: begin
                state_next = slb_pkg::ST_READ;
            end
            slb_pkg::ST_READ: begin
                if (xi_reg == x1_reg && yi_reg == y1_reg) begin
                    state_next = slb_pkg::ST_READ_END;
                end
            end
            slb_pkg::ST_READ_END: begin
                state_next = slb_pkg::ST_MUL;
            end
            slb_pkg::ST_MUL: begin
                state_next = slb_pkg::ST_MEAN_GO;
            end
            slb_pkg::ST_MEAN_GO: begin
                div_start  = 1'b1;
                state_next = slb_pkg::ST_MEAN_WAIT;
            end
            slb_pkg::ST_MEAN_WAIT: begin
                if (div_done) begin
                    state_next = slb_pkg::ST_VAR_GO;
                end
            end
            slb_pkg::ST_VAR_GO: begin
                div_start    = 1'b1;
                div_dividend = NUM_W'({var_diff, 16'd0});
                div_divisor  = den_reg;
                state_next   = slb_pkg::ST_VAR_WAIT;
            end
            slb_pkg::ST_VAR_WAIT: begin
                if (div_done) begin
                    state_next = slb_pkg::ST_SQ_GO;
                end
            end
            slb_pkg::ST_SQ_GO: begin
                sq_start   = 1'b1;
                state_next = slb_pkg::ST_SQ_WAIT;
            end
            slb_pkg::ST_SQ_WAIT: begin
                if (sq_done) begin
                    state_next = slb_pkg::ST_RAT_GO;
                end
            end
            slb_pkg::ST_RAT_GO: begin
                div_start    = 1'b1;
                div_dividend = NUM_W'(sd_reg);
                div_divisor  = DEN_W'(rdiv_eff);
                state_next   = slb_pkg::ST_RAT_WAIT;
            end
            slb_pkg::ST_RAT_WAIT: begin
                if (div_done) begin
                    state_next = slb_pkg::ST_PROD;
                end
            end
            slb_pkg::ST_PROD: begin
                state_next = slb_pkg::ST_FACT;
            end
            slb_pkg::ST_FACT: begin
                state_next = slb_pkg::ST_SCALE;
            end
            slb_pkg::ST_SCALE: begin
                state_next = slb_pkg::ST_DONE;
            end
            slb_pkg::ST_DONE: begin
                if (!out_full_reg || m_ready) begin
                    state_next = slb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = slb_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration and positions
    always_comb begin
        case (cfg_index)
            slb_pkg::REG_IMAGE_WIDTH,
            slb_pkg::REG_IMAGE_HEIGHT,
            slb_pkg::REG_WINDOW_SIZE,
            slb_pkg::REG_K_FACTOR,
            slb_pkg::REG_RANGE_DIVISOR: cfg_hit = cfg_wr_en;
            default:                    cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= slb_pkg::WIDTH_RST;
            height_reg   <= slb_pkg::HEIGHT_RST;
            wsize_reg    <= slb_pkg::WSIZE_RST;
            k_reg        <= slb_pkg::K_RST;
            rdiv_reg     <= slb_pkg::RDIV_RST;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_idx_reg   <= '0;
            in_addr_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_idx_reg  <= '0;
            out_addr_reg <= '0;
            out_full_reg <= 1'b0;
            acc_en_reg   <= 1'b0;
        end else begin
            acc_en_reg <= (state_reg == slb_pkg::ST_READ);
            if (load_out) begin
                out_full_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                out_full_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    slb_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_data[slb_pkg::WIDTH_CFG_W-1:0];
                    slb_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_data[slb_pkg::HEIGHT_CFG_W-1:0];
                    slb_pkg::REG_WINDOW_SIZE:   wsize_reg  <= cfg_data[slb_pkg::WSIZE_CFG_W-1:0];
                    slb_pkg::REG_K_FACTOR:      k_reg      <= cfg_data[slb_pkg::K_W-1:0];
                    slb_pkg::REG_RANGE_DIVISOR: rdiv_reg   <= cfg_data[slb_pkg::RDIV_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (cfg_hit || (load_out && frame_end)) begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_idx_reg   <= '0;
                in_addr_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_idx_reg  <= '0;
                out_addr_reg <= '0;
            end else if (accept && px_ok) begin
                in_idx_reg  <= in_idx_reg + IDX_W'(1);
                in_addr_reg <= ADDR_W'(addr_inc);
                if ((WID_W)'(in_col_reg) + WID_W'(1) >= w_eff) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + ROW_W'(1);
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end else if (load_out) begin
                out_idx_reg <= out_idx_reg + IDX_W'(1);
                if (out_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    out_addr_reg <= '0;
                end else begin
                    out_addr_reg <= out_addr_reg + ADDR_W'(1);
                end
                if ((WID_W)'(out_col_reg) + WID_W'(1) >= w_eff) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + ROW_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (acc_en_reg) begin
            s_reg <= s_reg + S_W'(pr) + S_W'(pg) + S_W'(pb);
            q_reg <= q_reg + Q_W'(rr) + Q_W'(gg) + Q_W'(bb);
        end
        case (state_reg)
            slb_pkg::ST_IDLE: begin
                x0_reg <= x0_c;
                x1_reg <= x1_c;
                y0_reg <= y0_c;
                y1_reg <= y1_c;
                dx_reg <= HALF_W'(out_col_reg - x0_c);
                dy_reg <= HALF_W'(out_row_reg - y0_c);
            end
            slb_pkg::ST_SETUP: begin
                back_reg <= ADDR_W'(dy_reg) * ADDR_W'(w_eff) + ADDR_W'(dx_reg);
                c_reg    <= C_W'(3) * (C_W'(xn) * C_W'(yn));
                s_reg    <= '0;
                q_reg    <= '0;
            end
            slb_pkg::ST_ADDR: begin
                gray_reg <= gray_sum[23:16];
                cur_reg  <= ADDR_W'(back_sub);
                row_reg  <= ADDR_W'(back_sub);
                xi_reg   <= x0_reg;
                yi_reg   <= y0_reg;
            end
            slb_pkg::ST_READ: begin
                if (xi_reg == x1_reg) begin
                    xi_reg  <= x0_reg;
                    yi_reg  <= yi_reg + ROW_W'(1);
                    row_reg <= ADDR_W'(row_add);
                    cur_reg <= ADDR_W'(row_add);
                end else begin
                    xi_reg  <= xi_reg + COL_W'(1);
                    cur_reg <= ADDR_W'(cur_inc);
                end
            end
            slb_pkg::ST_MUL: begin
                cq_reg  <= CQ_W'(c_reg) * CQ_W'(q_reg);
                ss_reg  <= CQ_W'(s_reg) * CQ_W'(s_reg);
                den_reg <= DEN_W'(c_reg) * DEN_W'(c_reg - C_W'(1));
            end
            slb_pkg::ST_MEAN_WAIT: begin
                mean_reg <= div_quo[slb_pkg::MEAN_W-1:0];
            end
            slb_pkg::ST_VAR_WAIT: begin
                var_reg <= div_quo[slb_pkg::VAR_W-1:0];
            end
            slb_pkg::ST_SQ_WAIT: begin
                sd_reg <= sq_root;
            end
            slb_pkg::ST_RAT_WAIT: begin
                rat_reg <= div_quo[slb_pkg::RAT_W-1:0];
            end
            slb_pkg::ST_PROD: begin
                prod_reg <= slb_pkg::PROD_W'(k_s) * slb_pkg::PROD_W'(term);
            end
            slb_pkg::ST_FACT: begin
                f_reg <= fsum[slb_pkg::F_W-1:0];
            end
            slb_pkg::ST_SCALE: begin
                mf_reg <= slb_pkg::MF_W'(mean_reg) * slb_pkg::MF_W'(f_reg);
            end
            slb_pkg::ST_DONE: begin
                if (load_out) begin
                    out_reg.foreground <= gray_sh > mf_reg;
                    out_reg.frame_end  <= frame_end;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = out_full_reg;
    assign m_data  = out_reg;

    slb_pixel_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept && px_ok),
        .wr_addr (in_addr_reg),
        .wr_data ({s_data.red, s_data.green, s_data.blue}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    slb_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    slb_sqrt #(
        .OUT_W (slb_pkg::SD_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand ({var_reg, 16'd0}),
        .done     (sq_done),
        .root     (sq_root)
    );

endmodule

### rtl/slb_pixel_store.sv
// Circular pixel store: one write port, one read port with registered data.
// Depends on slb_pkg for the pixel width.
module slb_pixel_store #(
    parameter int DEPTH  = slb_pkg::DEF_MAX_WINDOW * slb_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [slb_pkg::PIX_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [slb_pkg::PIX_W-1:0] rd_data
);

    logic [slb_pkg::PIX_W-1:0] mem [DEPTH];
    logic [slb_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/slb_div.sv
// Restoring divider, one quotient bit per cycle.
// No package dependencies.
module slb_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/slb_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// No package dependencies.
module slb_sqrt #(
    parameter int OUT_W = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [2*OUT_W-1:0] radicand,
    output logic               done,
    output logic [OUT_W-1:0]   root
);

    localparam int IN_W  = 2 * OUT_W;
    localparam int RW    = OUT_W + 4;
    localparam int CNT_W = $clog2(OUT_W + 1);

    logic [IN_W-1:0]  val_reg;
    logic [RW-1:0]    rem_reg;
    logic [OUT_W-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RW-1:0]    rem_sh;
    logic [RW-1:0]    trial;
    logic             fits;

    always_comb begin
        rem_sh = {rem_reg[RW-3:0], val_reg[IN_W-1:IN_W-2]};
        trial  = {2'b00, root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(OUT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[IN_W-3:0], 2'b00};
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[OUT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
